// ===== src/bqc_pkg.sv =====
// Shared types, widths and constants for the biquad coefficient calculator.
// Holds the arctangent table of the CORDIC, the status codes and the sideband record.
// No dependencies.
`timescale 1ns / 1ps

package bqc_pkg;

   localparam int IN_W             = 20;
   localparam int TURN_W           = 32;
   localparam int COEF_W           = 32;
   localparam int CW               = 35;
   localparam int LANES            = 4;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int FRAC_BITS_DEF    = 28;

   localparam logic signed [CW-1:0] UNITY        = 35'sd1073741824;
   localparam logic signed [CW-1:0] QUARTER_TURN = 35'sd1073741824;
   localparam logic signed [CW-1:0] HALF_TURN    = 35'sd2147483648;
   localparam logic signed [CW-1:0] CORDIC_X0    = 35'sd652032874;

   localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
   localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NO_RATE = 2'd1,
      STATUS_FAULT   = 2'd2
   } status_type;

   typedef struct packed {
      logic highpass;
      logic no_rate;
      logic fold;
      logic bad_den;
   } meta_type;

   function automatic logic [TURN_W-1:0] atan_turn(input int unsigned idx);
      logic [TURN_W-1:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         23:      val = 32'h00000051;
         24:      val = 32'h00000029;
         25:      val = 32'h00000014;
         26:      val = 32'h0000000A;
         27:      val = 32'h00000005;
         28:      val = 32'h00000003;
         29:      val = 32'h00000001;
         30:      val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

// ===== src/bqc_turn_div.sv =====
// Pipelined restoring divider that turns cutoff over sample rate into a turn fraction.
// One quotient bit per register stage; the low 32 quotient bits are the fractional turn.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_turn_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_vld,
   input  bqc_pkg::meta_type          in_meta,
   input  logic [bqc_pkg::IN_W-1:0]   in_cutoff,
   input  logic [bqc_pkg::IN_W-1:0]   in_rate,
   output logic                       out_vld,
   output bqc_pkg::meta_type          out_meta,
   output logic [bqc_pkg::TURN_W-1:0] out_turn
);
   import bqc_pkg::*;

   localparam int STEPS = IN_W + TURN_W;

   wire              st_vld  [0:STEPS];
   wire meta_type    st_meta [0:STEPS];
   wire [IN_W-1:0]   st_rem  [0:STEPS];
   wire [IN_W-1:0]   st_num  [0:STEPS];
   wire [IN_W-1:0]   st_den  [0:STEPS];
   wire [TURN_W-1:0] st_quot [0:STEPS];

   assign st_vld[0]  = in_vld;
   assign st_meta[0] = in_meta;
   assign st_rem[0]  = '0;
   assign st_num[0]  = in_cutoff;
   assign st_den[0]  = in_rate;
   assign st_quot[0] = '0;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic [IN_W:0]   trial;
      logic [IN_W:0]   diff;
      logic            ge;
      logic [IN_W-1:0] rem_in;
      logic            vld_ff;
      meta_type        meta_ff;
      logic [IN_W-1:0] rem_ff;
      logic [IN_W-1:0] num_ff;
      logic [IN_W-1:0] den_ff;
      logic [TURN_W-1:0] quot_ff;

      always_comb begin
         trial  = {st_rem[k], st_num[k][IN_W-1]};
         diff   = trial - {1'b0, st_den[k]};
         ge     = (trial >= {1'b0, st_den[k]});
         rem_in = ge ? diff[IN_W-1:0] : trial[IN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= st_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            meta_ff <= st_meta[k];
            rem_ff  <= rem_in;
            num_ff  <= {st_num[k][IN_W-2:0], 1'b0};
            den_ff  <= st_den[k];
            quot_ff <= {st_quot[k][TURN_W-2:0], ge};
         end
      end

      assign st_vld[k+1]  = vld_ff;
      assign st_meta[k+1] = meta_ff;
      assign st_rem[k+1]  = rem_ff;
      assign st_num[k+1]  = num_ff;
      assign st_den[k+1]  = den_ff;
      assign st_quot[k+1] = quot_ff;
   end

   assign out_vld  = st_vld[STEPS];
   assign out_meta = st_meta[STEPS];
   assign out_turn = st_quot[STEPS];

endmodule

// ===== src/bqc_cordic.sv =====
// Rotation-mode CORDIC with one iteration per register stage.
// Produces cosine in x and sine in y for a folded angle given in turn units.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_cordic #(
   parameter int STEPS = bqc_pkg::CORDIC_STEPS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_vld,
   input  bqc_pkg::meta_type             in_meta,
   input  logic signed [bqc_pkg::CW-1:0] in_z,
   output logic                          out_vld,
   output bqc_pkg::meta_type             out_meta,
   output logic signed [bqc_pkg::CW-1:0] out_x,
   output logic signed [bqc_pkg::CW-1:0] out_y
);
   import bqc_pkg::*;

   wire                 st_vld  [0:STEPS];
   wire meta_type       st_meta [0:STEPS];
   wire signed [CW-1:0] st_x    [0:STEPS];
   wire signed [CW-1:0] st_y    [0:STEPS];
   wire signed [CW-1:0] st_z    [0:STEPS];

   assign st_vld[0]  = in_vld;
   assign st_meta[0] = in_meta;
   assign st_x[0]    = CORDIC_X0;
   assign st_y[0]    = '0;
   assign st_z[0]    = in_z;

   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [CW-1:0] ang;
      logic                 up;
      logic signed [CW-1:0] x_in;
      logic signed [CW-1:0] y_in;
      logic signed [CW-1:0] z_in;
      logic                 vld_ff;
      meta_type             meta_ff;
      logic signed [CW-1:0] x_ff;
      logic signed [CW-1:0] y_ff;
      logic signed [CW-1:0] z_ff;

      always_comb begin
         dx   = st_y[i] >>> i;
         dy   = st_x[i] >>> i;
         ang  = signed'({{(CW-TURN_W){1'b0}}, atan_turn(i)});
         up   = !st_z[i][CW-1];
         x_in = up ? (st_x[i] - dx) : (st_x[i] + dx);
         y_in = up ? (st_y[i] + dy) : (st_y[i] - dy);
         z_in = up ? (st_z[i] - ang) : (st_z[i] + ang);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= st_vld[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            meta_ff <= st_meta[i];
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
         end
      end

      assign st_vld[i+1]  = vld_ff;
      assign st_meta[i+1] = meta_ff;
      assign st_x[i+1]    = x_ff;
      assign st_y[i+1]    = y_ff;
      assign st_z[i+1]    = z_ff;
   end

   assign out_vld  = st_vld[STEPS];
   assign out_meta = st_meta[STEPS];
   assign out_x    = st_x[STEPS];
   assign out_y    = st_y[STEPS];

endmodule

// ===== src/bqc_quot.sv =====
// Four-lane pipelined divider for the rounded coefficient quotients.
// Adds half the divisor, flags quotients of 2^32 or more, then forms 32 bits, one per stage.
// Depends on bqc_pkg.
`timescale 1ns / 1ps

module bqc_quot #(
   parameter int FRAC = bqc_pkg::FRAC_BITS_DEF
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           en,
   input  logic                                           in_vld,
   input  bqc_pkg::meta_type                              in_meta,
   input  logic [bqc_pkg::LANES-1:0][bqc_pkg::CW-1:0]     in_mag,
   input  logic [bqc_pkg::LANES-1:0][bqc_pkg::CW-1:0]     in_den,
   input  logic [bqc_pkg::LANES-1:0]                      in_neg,
   output logic                                           out_vld,
   output bqc_pkg::meta_type                              out_meta,
   output logic [bqc_pkg::LANES-1:0][bqc_pkg::COEF_W-1:0] out_quot,
   output logic [bqc_pkg::LANES-1:0]                      out_over,
   output logic [bqc_pkg::LANES-1:0]                      out_neg
);
   import bqc_pkg::*;

   localparam int DW = CW;
   localparam int QW = COEF_W;
   localparam int NW = CW + FRAC + 1;

   logic [LANES-1:0][NW-1:0] num_in;
   logic                     a_vld_ff;
   meta_type                 a_meta_ff;
   logic [LANES-1:0][NW-1:0] a_num_ff;
   logic [LANES-1:0][DW-1:0] a_den_ff;
   logic [LANES-1:0]         a_neg_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num_in[l] = (NW'(in_mag[l]) << FRAC) + NW'(in_den[l] >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_meta_ff <= in_meta;
         a_num_ff  <= num_in;
         a_den_ff  <= in_den;
         a_neg_ff  <= in_neg;
      end
   end

   logic [LANES-1:0]         over_in;
   logic [LANES-1:0][DW-1:0] rem_in;
   logic                     b_vld_ff;
   meta_type                 b_meta_ff;
   logic [LANES-1:0][DW-1:0] b_rem_ff;
   logic [LANES-1:0][QW-1:0] b_low_ff;
   logic [LANES-1:0][DW-1:0] b_den_ff;
   logic [LANES-1:0]         b_over_ff;
   logic [LANES-1:0]         b_neg_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         over_in[l] = (a_num_ff[l][NW-1:QW] >= a_den_ff[l]);
         rem_in[l]  = DW'(a_num_ff[l][NW-1:QW]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_meta_ff <= a_meta_ff;
         b_over_ff <= over_in;
         b_neg_ff  <= a_neg_ff;
         b_den_ff  <= a_den_ff;
         b_rem_ff  <= rem_in;
         for (int l = 0; l < LANES; l++) begin
            b_low_ff[l] <= a_num_ff[l][QW-1:0];
         end
      end
   end

   wire                           st_vld  [0:QW];
   wire meta_type                 st_meta [0:QW];
   wire [LANES-1:0][DW-1:0]       st_rem  [0:QW];
   wire [LANES-1:0][QW-1:0]       st_low  [0:QW];
   wire [LANES-1:0][DW-1:0]       st_den  [0:QW];
   wire [LANES-1:0][QW-1:0]       st_quot [0:QW];
   wire [LANES-1:0]               st_over [0:QW];
   wire [LANES-1:0]               st_neg  [0:QW];

   assign st_vld[0]  = b_vld_ff;
   assign st_meta[0] = b_meta_ff;
   assign st_rem[0]  = b_rem_ff;
   assign st_low[0]  = b_low_ff;
   assign st_den[0]  = b_den_ff;
   assign st_quot[0] = '0;
   assign st_over[0] = b_over_ff;
   assign st_neg[0]  = b_neg_ff;

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [LANES-1:0][DW:0]   trial;
      logic [LANES-1:0][DW:0]   diff;
      logic [LANES-1:0]         ge;
      logic [LANES-1:0][DW-1:0] step_rem_in;
      logic [LANES-1:0][QW-1:0] step_low_in;
      logic [LANES-1:0][QW-1:0] step_quot_in;
      logic                     vld_ff;
      meta_type                 meta_ff;
      logic [LANES-1:0][DW-1:0] rem_ff;
      logic [LANES-1:0][QW-1:0] low_ff;
      logic [LANES-1:0][DW-1:0] den_ff;
      logic [LANES-1:0][QW-1:0] quot_ff;
      logic [LANES-1:0]         over_ff;
      logic [LANES-1:0]         neg_ff;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l]        = {st_rem[k][l], st_low[k][l][QW-1]};
            diff[l]         = trial[l] - {1'b0, st_den[k][l]};
            ge[l]           = (trial[l] >= {1'b0, st_den[k][l]});
            step_rem_in[l]  = ge[l] ? diff[l][DW-1:0] : trial[l][DW-1:0];
            step_low_in[l]  = {st_low[k][l][QW-2:0], 1'b0};
            step_quot_in[l] = {st_quot[k][l][QW-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= st_vld[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            meta_ff <= st_meta[k];
            rem_ff  <= step_rem_in;
            low_ff  <= step_low_in;
            den_ff  <= st_den[k];
            quot_ff <= step_quot_in;
            over_ff <= st_over[k];
            neg_ff  <= st_neg[k];
         end
      end

      assign st_vld[k+1]  = vld_ff;
      assign st_meta[k+1] = meta_ff;
      assign st_rem[k+1]  = rem_ff;
      assign st_low[k+1]  = low_ff;
      assign st_den[k+1]  = den_ff;
      assign st_quot[k+1] = quot_ff;
      assign st_over[k+1] = over_ff;
      assign st_neg[k+1]  = neg_ff;
   end

   assign out_vld  = st_vld[QW];
   assign out_meta = st_meta[QW];
   assign out_quot = st_quot[QW];
   assign out_over = st_over[QW];
   assign out_neg  = st_neg[QW];

endmodule

// ===== src/biquad_coefficient_calculator.sv =====
// Lowpass or highpass biquad coefficient calculator with Q fixed at one half.
// Top level; depends on bqc_pkg, bqc_turn_div, bqc_cordic and bqc_quot.
//
// Usage: a request beat carries the filter kind, the cutoff and the sample rate
// in hertz. Each request beat yields exactly one response beat with the five
// coefficients (signed, FRAC_BITS fraction bits) and a status code, in order.
// The datapath is a single pipeline: 52 divider stages for the turn fraction,
// one folding stage, CORDIC_STEPS rotation stages, one stage forming the
// numerators and divisors, two preparation stages and 32 quotient stages of the
// four-lane divider, and the output register. A new request is taken every cycle
// while the response side does not stall.
// Status 1 marks a zero sample rate, status 2 a divisor that is not positive or a
// coefficient that saturated; the coefficients are zero in the first two cases.
// Reset empties the pipeline and the output register. While the response
// side stalls a held beat, the whole pipeline holds and req_stall is raised in
// the same cycle; no beat is lost or repeated.
`timescale 1ns / 1ps

module biquad_coefficient_calculator #(
   parameter int CORDIC_STEPS = bqc_pkg::CORDIC_STEPS_DEF,
   parameter int FRAC_BITS    = bqc_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [bqc_pkg::IN_W-1:0]         req_cutoff_hz,
   input  logic [bqc_pkg::IN_W-1:0]         req_sample_rate_hz,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [bqc_pkg::COEF_W-1:0] rsp_gain_current_in,
   output logic signed [bqc_pkg::COEF_W-1:0] rsp_gain_prev_in,
   output logic signed [bqc_pkg::COEF_W-1:0] rsp_gain_prev_prev_in,
   output logic signed [bqc_pkg::COEF_W-1:0] rsp_gain_prev_out,
   output logic signed [bqc_pkg::COEF_W-1:0] rsp_gain_prev_prev_out,
   output logic [1:0]                       rsp_status
);
   import bqc_pkg::*;

   logic     rsp_valid_ff;
   logic     adv;
   meta_type req_meta;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_comb begin
      req_meta          = '0;
      req_meta.highpass = req_type;
      req_meta.no_rate  = (req_sample_rate_hz == '0);
   end

   logic              t_vld;
   meta_type          t_meta;
   logic [TURN_W-1:0] t_turn;

   bqc_turn_div u_turn_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_vld    (req_valid),
      .in_meta   (req_meta),
      .in_cutoff (req_cutoff_hz),
      .in_rate   (req_sample_rate_hz),
      .out_vld   (t_vld),
      .out_meta  (t_meta),
      .out_turn  (t_turn)
   );

   logic signed [CW-1:0] z_wide;
   logic signed [CW-1:0] z_in;
   meta_type             f_meta_in;
   logic                 f_vld_ff;
   meta_type             f_meta_ff;
   logic signed [CW-1:0] f_z_ff;

   always_comb begin
      z_wide    = signed'({{(CW-TURN_W){t_turn[TURN_W-1]}}, t_turn});
      f_meta_in = t_meta;
      z_in      = z_wide;
      if (z_wide > QUARTER_TURN) begin
         z_in           = z_wide - HALF_TURN;
         f_meta_in.fold = 1'b1;
      end else if (z_wide < -QUARTER_TURN) begin
         z_in           = z_wide + HALF_TURN;
         f_meta_in.fold = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= t_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_meta_ff <= f_meta_in;
         f_z_ff    <= z_in;
      end
   end

   logic                 c_vld;
   meta_type             c_meta;
   logic signed [CW-1:0] c_x;
   logic signed [CW-1:0] c_y;

   bqc_cordic #(
      .STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (f_vld_ff),
      .in_meta  (f_meta_ff),
      .in_z     (f_z_ff),
      .out_vld  (c_vld),
      .out_meta (c_meta),
      .out_x    (c_x),
      .out_y    (c_y)
   );

   logic signed [CW-1:0]     cos_v;
   logic signed [CW-1:0]     sin_v;
   logic signed [CW-1:0]     den_v;
   logic signed [CW-1:0]     nb;
   logic signed [CW-1:0]     num [LANES];
   logic signed [CW-1:0]     lane_den [LANES];
   logic signed [CW-1:0]     abs_v;
   logic [LANES-1:0][CW-1:0] mag_in;
   logic [LANES-1:0][CW-1:0] den_in;
   logic [LANES-1:0]         neg_in;
   meta_type                 p_meta_in;
   logic                     p_vld_ff;
   meta_type                 p_meta_ff;
   logic [LANES-1:0][CW-1:0] p_mag_ff;
   logic [LANES-1:0][CW-1:0] p_den_ff;
   logic [LANES-1:0]         p_neg_ff;

   always_comb begin
      cos_v     = c_meta.fold ? -c_x : c_x;
      sin_v     = c_meta.fold ? -c_y : c_y;
      den_v     = UNITY + sin_v;
      nb        = c_meta.highpass ? (UNITY + cos_v) : (UNITY - cos_v);
      p_meta_in = c_meta;
      p_meta_in.bad_den = den_v[CW-1] || (den_v == '0);
      num[0]      = nb;
      lane_den[0] = den_v <<< 1;
      num[1]      = c_meta.highpass ? -nb : nb;
      lane_den[1] = den_v;
      num[2]      = -(cos_v <<< 1);
      lane_den[2] = den_v;
      num[3]      = UNITY - sin_v;
      lane_den[3] = den_v;
      abs_v       = '0;
      for (int l = 0; l < LANES; l++) begin
         neg_in[l] = num[l][CW-1];
         abs_v     = neg_in[l] ? -num[l] : num[l];
         mag_in[l] = abs_v;
         den_in[l] = lane_den[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= c_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_meta_ff <= p_meta_in;
         p_mag_ff  <= mag_in;
         p_den_ff  <= den_in;
         p_neg_ff  <= neg_in;
      end
   end

   logic                         q_vld;
   meta_type                     q_meta;
   logic [LANES-1:0][COEF_W-1:0] q_quot;
   logic [LANES-1:0]             q_over;
   logic [LANES-1:0]             q_neg;

   bqc_quot #(
      .FRAC (FRAC_BITS)
   ) u_quot (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_vld   (p_vld_ff),
      .in_meta  (p_meta_ff),
      .in_mag   (p_mag_ff),
      .in_den   (p_den_ff),
      .in_neg   (p_neg_ff),
      .out_vld  (q_vld),
      .out_meta (q_meta),
      .out_quot (q_quot),
      .out_over (q_over),
      .out_neg  (q_neg)
   );

   logic [LANES-1:0][COEF_W-1:0] coef_in;
   logic [LANES-1:0]             sat;
   status_type                   status_in;
   logic [LANES-1:0][COEF_W-1:0] coef_ff;
   status_type                   status_ff;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (q_neg[l]) begin
            sat[l]     = q_over[l] || (q_quot[l] > COEF_MIN);
            coef_in[l] = sat[l] ? COEF_MIN : (~q_quot[l] + 1'b1);
         end else begin
            sat[l]     = q_over[l] || q_quot[l][COEF_W-1];
            coef_in[l] = sat[l] ? COEF_MAX : q_quot[l];
         end
      end
      status_in = (|sat) ? STATUS_FAULT : STATUS_OK;
      if (q_meta.no_rate) begin
         status_in = STATUS_NO_RATE;
         coef_in   = '0;
      end else if (q_meta.bad_den) begin
         status_in = STATUS_FAULT;
         coef_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         coef_ff   <= coef_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_gain_current_in    = signed'(coef_ff[0]);
   assign rsp_gain_prev_in       = signed'(coef_ff[1]);
   assign rsp_gain_prev_prev_in  = signed'(coef_ff[0]);
   assign rsp_gain_prev_out      = signed'(coef_ff[2]);
   assign rsp_gain_prev_prev_out = signed'(coef_ff[3]);
   assign rsp_status             = status_ff;

   a_zero_on_no_rate: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_NO_RATE)) |->
         ((rsp_gain_current_in == '0) && (rsp_gain_prev_in == '0) &&
          (rsp_gain_prev_out == '0) && (rsp_gain_prev_prev_out == '0)))
      else $error("Zero sample rate response carries nonzero coefficients.");

   a_outer_taps_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_gain_prev_prev_in == rsp_gain_current_in))
      else $error("Outer feedforward coefficients differ.");

   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_gain_current_in) &&
          $stable(rsp_gain_prev_in) && $stable(rsp_gain_prev_out) &&
          $stable(rsp_gain_prev_prev_out)))
      else $error("Pipeline moved while the response beat was stalled.");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the biquad coefficient calculator.
// Predicts every response from the request fields and compares beats in order;
// depends on bqc_pkg and the biquad_coefficient_calculator RTL.
`timescale 1ns / 1ps

module testbench;
   import bqc_pkg::*;

   typedef struct packed {
      logic signed [31:0] b0;
      logic signed [31:0] b1;
      logic signed [31:0] b2;
      logic signed [31:0] a1;
      logic signed [31:0] a2;
      status_type         st;
   } coef_set_type;

   class coef_scoreboard;
      coef_set_type pending_sets[$];
      int           errors;

      static function longint limit_quot(longint num, longint den, ref bit sat);
         bit              neg;
         longint unsigned mag;
         longint unsigned q;
         neg = num < 0;
         mag = neg ? longint'(-num) : num;
         q = ((mag << 28) + longint'(den) / 2) / longint'(den);
         if (!neg) begin
            if (q > 64'h7FFF_FFFF) begin
               sat = 1;
               return 64'sh7FFF_FFFF;
            end
            return q;
         end
         if (q > 64'h8000_0000) begin
            sat = 1;
            return -64'sh8000_0000;
         end
         return -longint'(q);
      endfunction

      static function coef_set_type design_coefs(logic kind, logic [19:0] fc,
                                                 logic [19:0] fs);
         longint unsigned turn_tab[32] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
            64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
            64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
            64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
            64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
            64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
            64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
         coef_set_type    r;
         longint unsigned turn;
         longint          z, x, y, dx, dy, c, s, d, nb;
         bit              fold, sat;
         r = '0;
         r.st = STATUS_OK;
         if (fs == 0) begin
            r.st = STATUS_NO_RATE;
            return r;
         end
         turn = ((longint'(fc) % longint'(fs)) << 32) / longint'(fs);
         z = turn;
         x = 652032874;
         y = 0;
         fold = 0;
         sat = 0;
         if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
         if (z > (64'sd1 << 30)) begin
            z -= (64'sd1 << 31);
            fold = 1;
         end else if (z < -(64'sd1 << 30)) begin
            z += (64'sd1 << 31);
            fold = 1;
         end
         for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= longint'(turn_tab[i]);
            end else begin
               x += dx;
               y -= dy;
               z += longint'(turn_tab[i]);
            end
         end
         c = fold ? -x : x;
         s = fold ? -y : y;
         d = (64'sd1 << 30) + s;
         if (d <= 0) begin
            r.st = STATUS_FAULT;
            return r;
         end
         nb = kind ? ((64'sd1 << 30) + c) : ((64'sd1 << 30) - c);
         r.b0 = 32'(limit_quot(nb, 2 * d, sat));
         r.b1 = 32'(limit_quot(kind ? -nb : nb, d, sat));
         r.b2 = r.b0;
         r.a1 = 32'(limit_quot(-2 * c, d, sat));
         r.a2 = 32'(limit_quot((64'sd1 << 30) - s, d, sat));
         if (sat) r.st = STATUS_FAULT;
         return r;
      endfunction

      function void note_request(logic kind, logic [19:0] fc, logic [19:0] fs);
         pending_sets.push_back(design_coefs(kind, fc, fs));
      endfunction

      function void check_response(coef_set_type got);
         coef_set_type want;
         if (pending_sets.size() == 0) begin
            $display("%0t: response beat with nothing expected", $time);
            errors++;
            return;
         end
         want = pending_sets.pop_front();
         if (got.b0 !== want.b0) begin
            $display("%0t: gain_current_in expected %0d actual %0d", $time, want.b0, got.b0);
            errors++;
         end
         if (got.b1 !== want.b1) begin
            $display("%0t: gain_prev_in expected %0d actual %0d", $time, want.b1, got.b1);
            errors++;
         end
         if (got.b2 !== want.b2) begin
            $display("%0t: gain_prev_prev_in expected %0d actual %0d", $time, want.b2,
                     got.b2);
            errors++;
         end
         if (got.a1 !== want.a1) begin
            $display("%0t: gain_prev_out expected %0d actual %0d", $time, want.a1, got.a1);
            errors++;
         end
         if (got.a2 !== want.a2) begin
            $display("%0t: gain_prev_prev_out expected %0d actual %0d", $time, want.a2,
                     got.a2);
            errors++;
         end
         if (got.st !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_type = 0;
   logic [19:0] req_cutoff_hz = 0;
   logic [19:0] req_sample_rate_hz = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic signed [31:0] rsp_gain_current_in, rsp_gain_prev_in, rsp_gain_prev_prev_in;
   logic signed [31:0] rsp_gain_prev_out, rsp_gain_prev_prev_out;
   logic [1:0]  rsp_status;

   coef_scoreboard sb = new();
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   biquad_coefficient_calculator u_dut (.*);

   always #4 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_type, req_cutoff_hz, req_sample_rate_hz);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response({rsp_gain_current_in, rsp_gain_prev_in, rsp_gain_prev_prev_in,
                            rsp_gain_prev_out, rsp_gain_prev_prev_out,
                            status_type'(rsp_status)});
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 5000) begin
         $display("biquad_coefficient_calculator regression: fail");
         $finish;
      end
   end

   task automatic send_request(logic kind, logic [19:0] fc, logic [19:0] fs);
      bit taken;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 0;
      end
      @(negedge clock);
      req_valid <= 1;
      req_type <= kind;
      req_cutoff_hz <= fc;
      req_sample_rate_hz <= fs;
      taken = 0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
   endtask

   task automatic send_random_request();
      logic [19:0] fc, fs;
      int pick;
      pick = $urandom_range(99);
      fs = 20'($urandom);
      fc = 20'($urandom);
      if (pick < 3) fs = 0;
      else if (pick < 30) begin
         fs = 20'($urandom_range(96000, 8000));
         fc = 20'($urandom_range(fs));
      end else if (pick < 45) begin
         fs = 20'($urandom_range(16, 1));
         fc = 20'($urandom_range(40));
      end else if (pick < 55) fc = fs;
      send_request(1'($urandom_range(1)), fc, fs);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (sb.pending_sets.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      send_request(0, 1000, 48000);
      send_request(1, 1000, 48000);
      send_request(0, 0, 48000);
      send_request(1, 0, 48000);
      send_request(0, 5, 0);
      send_request(1, 20'hFFFFF, 0);
      send_request(0, 20'hFFFFF, 20'hFFFFF);
      send_request(1, 20'hFFFFE, 20'hFFFFF);
      send_request(0, 12000, 48000);
      send_request(1, 12000, 48000);
      send_request(0, 24000, 48000);
      send_request(1, 24000, 48000);
      send_request(0, 36000, 48000);
      send_request(1, 36000, 48000);
      send_request(0, 100000, 48000);
      send_request(1, 1, 2);
      send_request(0, 3, 4);
      send_request(1, 1, 4);
      send_request(0, 20'hFFFFF, 1);
      send_request(1, 1, 20'hFFFFF);
      send_request(0, 20'h55555, 20'hAAAAA);
      send_request(1, 20'hAAAAA, 20'h55555);
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 1) ? 75 : (phase == 3) ? 15 : 0;
         stall_pct = (phase == 2) ? 75 : (phase == 3) ? 15 : 0;
         if (phase == 2) drain();
         for (int n = 0; n < 275; n++) send_random_request();
      end
      drain();
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.pending_sets.size() == 0)
         $display("biquad_coefficient_calculator regression: pass");
      else
         $display("biquad_coefficient_calculator regression: fail");
      $finish;
   end
endmodule

// ===== sim.f =====
src/bqc_pkg.sv
src/bqc_turn_div.sv
src/bqc_cordic.sv
src/bqc_quot.sv
src/biquad_coefficient_calculator.sv
dv/testbench.sv
